>>> src/bba_pkg.sv
// shared types, constants and helper functions for the buddy block allocator
// no dependencies; imported by bba_core and buddy_block_allocator_unit
package bba_pkg;

  localparam int LEVELS    = 16;
  localparam int TOP_MAX   = LEVELS - 1;
  localparam int NODE_W    = LEVELS;
  localparam int BIT_W     = 6;
  localparam int WORD_W    = 1 << BIT_W;
  localparam int ADDR_W    = NODE_W - BIT_W;
  localparam int MAP_DEPTH = 1 << ADDR_W;
  localparam int LVL_W     = 4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_MEM   = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] CFG_BASE   = 2'd0;
  localparam logic [1:0] CFG_TOTAL  = 2'd1;
  localparam logic [1:0] CFG_MINBLK = 2'd2;

  localparam logic [4:0] RST_TOTAL  = 5'd20;
  localparam logic [4:0] RST_MINBLK = 5'd5;

  typedef struct packed {
    logic [31:0] base;
    logic [4:0]  total_shift;
    logic [4:0]  min_shift;
  } bba_cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] size;
    logic [31:0] addr;
  } bba_req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] addr;
  } bba_res_t;

  function automatic logic [LVL_W-1:0] top_level(input bba_cfg_t c);
    logic [4:0] d;
    d = c.total_shift - c.min_shift;
    if (c.total_shift <= c.min_shift) return '0;
    else if (d > 5'(TOP_MAX)) return LVL_W'(TOP_MAX);
    else return d[LVL_W-1:0];
  endfunction

  // nodes [lo, 2lo) inside one map word; whole word once lo reaches a word
  function automatic logic [WORD_W-1:0] level_mask(input logic [NODE_W-1:0] lo);
    logic [WORD_W-1:0] m;
    if (lo >= NODE_W'(WORD_W)) m = '1;
    else m = ((WORD_W'(1) << lo[BIT_W-1:0]) - WORD_W'(1)) << lo[BIT_W-1:0];
    return m;
  endfunction

  function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

endpackage

>>> src/bba_core.sv
// request sequencer and free-bitmap memory of the buddy block allocator
// depends on bba_pkg
module bba_core import bba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     clear_req,
  input  bba_cfg_t cfg,
  input  logic     req_valid,
  input  bba_req_t req,
  output logic     idle,
  output logic     res_valid,
  output bba_res_t res,
  input  logic     res_take
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CHK, S_TGT,
    S_ASET, S_ARD, S_AEV, S_ACLR, S_SRD, S_SEV, S_AOUT,
    S_FOFF, S_FCHK, S_FRD, S_FEV, S_MRD, S_MEV, S_PRD, S_PWR,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [ADDR_W-1:0]   clr_r;
  logic                cmd_r;
  logic [31:0]         size_r;
  logic [31:0]         addr_r;
  logic [31:0]         off_r;
  logic [LVL_W-1:0]    top_r;
  logic [LVL_W-1:0]    tgt_r;
  logic [LVL_W-1:0]    lvl_r;
  logic [ADDR_W-1:0]   w_r;
  logic [ADDR_W-1:0]   wend_r;
  logic [NODE_W-1:0]   n_r;
  logic [NODE_W-1:0]   a_r;
  status_t             status_r;
  logic [31:0]         gaddr_r;

  logic [WORD_W-1:0]   mem [MAP_DEPTH];
  logic [WORD_W-1:0]   rdata_r;
  logic                mem_we;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [WORD_W-1:0]   mem_wdata;

  logic [5:0]          e_top;
  logic [5:0]          e_tgt;
  logic                over_total;
  logic                over_top;
  logic                tgt_small;
  logic [NODE_W-1:0]   lo;
  logic [NODE_W:0]     lo2m1;
  logic [NODE_W-1:0]   lo_tgt;
  logic [WORD_W-1:0]   hit;
  logic                off_range;
  logic                off_misalign;
  logic [31:0]         off_shr;
  logic [NODE_W-1:0]   n_free;
  logic [NODE_W-1:0]   diff;
  logic [31:0]         blk_off;
  logic [BIT_W-1:0]    buddy_bit;

  assign e_top      = {1'b0, cfg.min_shift} + {2'b0, top_r};
  assign e_tgt      = {1'b0, cfg.min_shift} + {2'b0, tgt_r};
  assign over_total = {1'b0, size_r} > (33'd1 << cfg.total_shift);
  assign over_top   = (e_top < 6'd32) && ({1'b0, size_r} > (33'd1 << e_top[4:0]));
  assign tgt_small  = (e_tgt < 6'd32) && ((33'd1 << e_tgt[4:0]) < {1'b0, size_r});
  assign lo         = NODE_W'(1) << (top_r - lvl_r);
  assign lo2m1      = {lo, 1'b0} - (NODE_W+1)'(1);
  assign lo_tgt     = NODE_W'(1) << (top_r - tgt_r);
  assign hit        = rdata_r & level_mask(lo);

  assign off_range    = (e_top < 6'd32) && ({1'b0, off_r} >= (33'd1 << e_top[4:0]));
  assign off_misalign = (e_tgt >= 6'd32) ? (off_r != 32'd0)
                      : ((off_r & ((32'd1 << e_tgt[4:0]) - 32'd1)) != 32'd0);
  assign off_shr      = (e_tgt >= 6'd32) ? 32'd0 : (off_r >> e_tgt[4:0]);
  assign n_free       = lo_tgt + off_shr[NODE_W-1:0];
  assign diff         = n_r - lo_tgt;
  assign blk_off      = (e_tgt >= 6'd32) ? 32'd0 : ({16'b0, diff} << e_tgt[4:0]);
  assign buddy_bit    = {n_r[BIT_W-1:1], ~n_r[0]};

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = n_r[NODE_W-1:BIT_W];
    mem_raddr = n_r[NODE_W-1:BIT_W];
    mem_wdata = rdata_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        // word 0 holds node 1, the whole-region block
        mem_wdata = (clr_r == '0) ? WORD_W'(2) : '0;
      end
      S_ARD: begin
        mem_re    = 1'b1;
        mem_raddr = w_r;
      end
      S_ACLR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_r & ~(WORD_W'(1) << n_r[BIT_W-1:0]);
      end
      S_SRD: begin
        mem_re    = 1'b1;
        mem_raddr = n_r[NODE_W-2:BIT_W-1];
      end
      S_SEV: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_r | (WORD_W'(1) << {n_r[BIT_W-1:1], 1'b1});
      end
      S_FRD: begin
        mem_re    = 1'b1;
        mem_raddr = a_r[NODE_W-1:BIT_W];
      end
      S_MRD, S_PRD: mem_re = 1'b1;
      S_MEV: begin
        mem_we    = rdata_r[buddy_bit];
        mem_wdata = rdata_r & ~(WORD_W'(1) << buddy_bit);
      end
      S_PWR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_r | (WORD_W'(1) << n_r[BIT_W-1:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else if (clear_req) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + ADDR_W'(1);
          if (clr_r == ADDR_W'(MAP_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            cmd_r   <= req.cmd;
            size_r  <= req.size;
            addr_r  <= req.addr;
            top_r   <= top_level(cfg);
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          gaddr_r <= '0;
          if (size_r == 32'd0 || over_total || over_top) begin
            status_r <= ST_BAD_SIZE;
            state_r  <= S_DONE;
          end else begin
            tgt_r   <= '0;
            state_r <= S_TGT;
          end
        end
        S_TGT: begin
          if (tgt_small && tgt_r < top_r) tgt_r <= tgt_r + LVL_W'(1);
          else if (cmd_r == CMD_FREE) state_r <= S_FOFF;
          else begin
            lvl_r   <= tgt_r;
            state_r <= S_ASET;
          end
        end
        S_ASET: begin
          w_r     <= lo[NODE_W-1:BIT_W];
          wend_r  <= lo2m1[NODE_W-1:BIT_W];
          state_r <= S_ARD;
        end
        S_ARD: state_r <= S_AEV;
        S_AEV: begin
          if (hit != '0) begin
            n_r     <= {w_r, first_set(hit)};
            state_r <= S_ACLR;
          end else if (w_r == wend_r) begin
            if (lvl_r == top_r) begin
              status_r <= ST_NO_MEM;
              state_r  <= S_DONE;
            end else begin
              lvl_r   <= lvl_r + LVL_W'(1);
              state_r <= S_ASET;
            end
          end else begin
            w_r     <= w_r + ADDR_W'(1);
            state_r <= S_ARD;
          end
        end
        S_ACLR: state_r <= (lvl_r > tgt_r) ? S_SRD : S_AOUT;
        S_SRD: begin
          // descend to the left child; the right child is set free next
          n_r     <= {n_r[NODE_W-2:0], 1'b0};
          lvl_r   <= lvl_r - LVL_W'(1);
          state_r <= S_SEV;
        end
        S_SEV: state_r <= (lvl_r > tgt_r) ? S_SRD : S_AOUT;
        S_AOUT: begin
          status_r <= ST_OK;
          gaddr_r  <= cfg.base + blk_off;
          state_r  <= S_DONE;
        end
        S_FOFF: begin
          off_r   <= addr_r - cfg.base;
          state_r <= S_FCHK;
        end
        S_FCHK: begin
          if (off_range || off_misalign) begin
            status_r <= ST_BAD_FREE;
            state_r  <= S_DONE;
          end else begin
            n_r     <= n_free;
            a_r     <= n_free;
            state_r <= S_FRD;
          end
        end
        S_FRD: state_r <= S_FEV;
        S_FEV: begin
          // the block or any enclosing block already free
          if (rdata_r[a_r[BIT_W-1:0]]) begin
            status_r <= ST_BAD_FREE;
            state_r  <= S_DONE;
          end else if (a_r[NODE_W-1:1] == '0) begin
            lvl_r   <= tgt_r;
            state_r <= S_MRD;
          end else begin
            a_r     <= a_r >> 1;
            state_r <= S_FRD;
          end
        end
        S_MRD: state_r <= (lvl_r < top_r) ? S_MEV : S_PRD;
        S_MEV: begin
          if (rdata_r[buddy_bit]) begin
            n_r     <= n_r >> 1;
            lvl_r   <= lvl_r + LVL_W'(1);
            state_r <= S_MRD;
          end else state_r <= S_PRD;
        end
        S_PRD: state_r <= S_PWR;
        S_PWR: begin
          status_r <= ST_OK;
          state_r  <= S_DONE;
        end
        S_DONE: if (res_take) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign idle       = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);
  assign res.status = status_r;
  assign res.addr   = gaddr_r;

endmodule

>>> src/buddy_block_allocator_unit.sv
// top level of the buddy block allocator: stream ports, config registers, result register
// depends on bba_pkg and bba_core

// Buddy allocator over one power-of-two region with a free bitmap per level held in a
// 1024 x 64 single-write memory. After reset and after every write to the base, total or
// minimum-block register the map is rebuilt by a clearing pass over all 1024 words during
// which no request is taken. A request is handled by one sequencer, one memory word access
// at a time: setup and size checks, size rounding one level at a time, then for an allocate
// a scan of the bitmap words of each candidate level and one split per level down to the
// target; for a free the offset checks, a check of each enclosing block, one merge per
// level and a write of the freed block. An allocate may have to scan the large sparse
// lower levels of a 16-level region. A finished result sits in an output register so the
// next request can start.
module buddy_block_allocator_unit import bba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // request_size [31:0], block_address [63:32]
  input  logic [0:0]  in_tuser,   // command [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // granted_address [31:0]
  output logic [1:0]  out_tuser,  // status [1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  bba_cfg_t cfg_r;
  bba_req_t req;
  bba_res_t res;
  bba_res_t out_res_r;
  logic     out_tvalid_r;
  logic     core_idle;
  logic     res_valid;
  logic     res_take;
  logic     cfg_wr;
  logic     clear_req;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign clear_req = cfg_wr && (cfg_index == CFG_BASE || cfg_index == CFG_TOTAL ||
                                cfg_index == CFG_MINBLK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base        <= '0;
      cfg_r.total_shift <= RST_TOTAL;
      cfg_r.min_shift   <= RST_MINBLK;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_BASE:   cfg_r.base        <= cfg_data;
        CFG_TOTAL:  cfg_r.total_shift <= cfg_data[4:0];
        CFG_MINBLK: cfg_r.min_shift   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign req.cmd  = in_tuser[0];
  assign req.size = in_tdata[31:0];
  assign req.addr = in_tdata[63:32];

  bba_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear_req (clear_req),
    .cfg       (cfg_r),
    .req_valid (in_tvalid),
    .req       (req),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  assign in_tready = core_idle;
  assign res_take  = res_valid && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else if (res_take) out_tvalid_r <= 1'b1;
    else if (out_tready) out_tvalid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_take) out_res_r <= res;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_res_r.addr;
  assign out_tuser  = out_res_r.status;

  // an address goes out only with a successful allocate
  a_addr_zero_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == 32'd0)
    else $error("nonzero address on error status");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !clear_req |=> !in_tready)
    else $error("request transaction did not start the sequencer");

  a_clear_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    clear_req |=> !in_tready)
    else $error("requests taken during map clearing");

endmodule
